// ===== hw/rtl/ljpf_pkg.sv =====
// Shared widths, register codes, types and output saturation for the pair force pipeline.
package ljpf_pkg;

  localparam int POS_W   = 32;
  localparam int DIFF_W  = POS_W + 1;
  localparam int CUT_W   = 40;
  localparam int CFG_W   = 40;
  localparam int COEF_W  = 32;
  localparam int RES_W   = 48;
  localparam int OP_W    = 62;
  localparam int HALF_W  = OP_W / 2;
  localparam int CAP_W   = 60;
  localparam int MAG_W   = CAP_W + 2;
  localparam int MUL_LAT = 3;

  localparam logic [CAP_W-1:0] CAP      = '1;
  localparam logic [CAP_W-1:0] FR_LIMIT = CAP / CAP_W'(24);

  localparam logic signed [RES_W-1:0] RES_MAX = {1'b0, {(RES_W-1){1'b1}}};
  localparam logic signed [RES_W-1:0] RES_MIN = {1'b1, {(RES_W-1){1'b0}}};
  localparam logic [MAG_W-1:0] POS_LIM = (MAG_W'(1) << (RES_W - 1)) - MAG_W'(1);
  localparam logic [MAG_W-1:0] NEG_LIM = MAG_W'(1) << (RES_W - 1);

  typedef enum logic [1:0] {
    CFG_BOX_LENGTH = 2'd0,
    CFG_CUTOFF_SQ  = 2'd1,
    CFG_SIGMA_SQ   = 2'd2,
    CFG_EPSILON    = 2'd3
  } cfg_idx_t;

  typedef logic signed [DIFF_W-1:0] diff_t;

  typedef struct packed {
    diff_t dx;
    diff_t dy;
    diff_t dz;
  } diff3_t;

  // Applies a sign to a magnitude and clamps the result to the signed output range.
  function automatic logic signed [RES_W-1:0] sat_mag(input logic neg,
                                                      input logic [MAG_W-1:0] m);
    logic signed [RES_W-1:0] low;
    low = $signed(RES_W'(m));
    if (!neg) begin
      return (m > POS_LIM) ? RES_MAX : low;
    end
    return (m > NEG_LIM) ? RES_MIN : -low;
  endfunction

endpackage

// ===== hw/rtl/ljpf_delay.sv =====
// Enabled delay line that carries a valid bit alongside a side-data word.
module ljpf_delay #(
  parameter int W     = 1,
  parameter int DEPTH = 1
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         en,
  input  logic         vld_i,
  input  logic [W-1:0] d_i,
  output logic         vld_o,
  output logic [W-1:0] d_o
);

  logic [DEPTH-1:0] v_r;
  logic [W-1:0]     d_r [DEPTH];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      for (int i = 0; i < DEPTH; i++) begin
        if (i == 0) begin
          v_r[i] <= vld_i;
        end else begin
          v_r[i] <= v_r[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < DEPTH; i++) begin
        if (i == 0) begin
          d_r[i] <= d_i;
        end else begin
          d_r[i] <= d_r[i-1];
        end
      end
    end
  end

  assign vld_o = v_r[DEPTH-1];
  assign d_o   = d_r[DEPTH-1];

endmodule

// ===== hw/rtl/ljpf_mulq.sv =====
// Three-stage unsigned fixed-point multiplier with the product clamped to the cap.
module ljpf_mulq
  import ljpf_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic             clk,
  input  logic             en,
  input  logic [OP_W-1:0]  a_i,
  input  logic [OP_W-1:0]  b_i,
  output logic [CAP_W-1:0] p_o
);

  localparam int PP_W   = 2 * HALF_W;
  localparam int PROD_W = 2 * OP_W;

  logic [PP_W-1:0]   ll_r, lh_r, hl_r, hh_r;
  logic [PROD_W-1:0] prod_r;
  logic [PROD_W-1:0] prod_nxt, sh;
  logic [CAP_W-1:0]  p_r;

  assign prod_nxt = {hh_r, ll_r} + (PROD_W'({1'b0, lh_r} + {1'b0, hl_r}) << HALF_W);
  assign sh       = prod_r >> FRAC_BITS;

  always_ff @(posedge clk) begin
    if (en) begin
      ll_r   <= a_i[HALF_W-1:0]    * b_i[HALF_W-1:0];
      lh_r   <= a_i[HALF_W-1:0]    * b_i[OP_W-1:HALF_W];
      hl_r   <= a_i[OP_W-1:HALF_W] * b_i[HALF_W-1:0];
      hh_r   <= a_i[OP_W-1:HALF_W] * b_i[OP_W-1:HALF_W];
      prod_r <= prod_nxt;
      p_r    <= (|sh[PROD_W-1:CAP_W]) ? CAP : sh[CAP_W-1:0];
    end
  end

  assign p_o = p_r;

endmodule

// ===== hw/rtl/ljpf_geom.sv =====
// Minimum-image separation, squared distance and cutoff test over six pipeline stages.
module ljpf_geom
  import ljpf_pkg::*;
#(
  parameter int FRAC_BITS = 16,
  localparam int SQ_W = 2 * POS_W - FRAC_BITS,
  localparam int R2_W = SQ_W + 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             vld_i,
  input  logic [POS_W-1:0] a_x,
  input  logic [POS_W-1:0] a_y,
  input  logic [POS_W-1:0] a_z,
  input  logic [POS_W-1:0] b_x,
  input  logic [POS_W-1:0] b_y,
  input  logic [POS_W-1:0] b_z,
  input  logic [POS_W-1:0] box_len,
  input  logic [CUT_W-1:0] cutoff,
  output logic             vld_o,
  output logic [R2_W-1:0]  r2_o,
  output logic             rng_o,
  output diff3_t           d_o
);

  localparam int NSTG  = 6;
  localparam int WR_W  = DIFF_W + 1;
  localparam int CMP_W = (R2_W > CUT_W) ? R2_W : CUT_W;

  logic [NSTG-1:0]   v_r;
  logic [POS_W-1:0]  a [3];
  logic [POS_W-1:0]  b [3];
  diff_t             d1_r [3];
  diff_t             d2_r [3];
  diff_t             d3_r [3];
  diff_t             d4_r [3];
  diff_t             d5_r [3];
  diff_t             d6_r [3];
  diff_t             d2_nxt [3];
  logic [POS_W-1:0]  m3_r [3];
  logic [SQ_W-1:0]   sq4_r [3];
  logic [2*POS_W-1:0] prod [3];
  logic [R2_W-1:0]   r2_5_r, r2_6_r;
  logic              rng6_r;

  assign a[0] = a_x;
  assign a[1] = a_y;
  assign a[2] = a_z;
  assign b[0] = b_x;
  assign b[1] = b_y;
  assign b[2] = b_z;

  // Fold the raw difference once into the box when it exceeds half a box length.
  always_comb begin
    logic signed [WR_W-1:0] dd, two, len_s;
    len_s = $signed(WR_W'({1'b0, box_len}));
    for (int i = 0; i < 3; i++) begin
      dd  = WR_W'(d1_r[i]);
      two = dd <<< 1;
      if (two < -len_s) begin
        d2_nxt[i] = DIFF_W'(dd + len_s);
      end else if (two > len_s) begin
        d2_nxt[i] = DIFF_W'(dd - len_s);
      end else begin
        d2_nxt[i] = d1_r[i];
      end
      prod[i] = m3_r[i] * m3_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[NSTG-2:0], vld_i};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        d1_r[i]  <= $signed({1'b0, a[i]}) - $signed({1'b0, b[i]});
        d2_r[i]  <= d2_nxt[i];
        m3_r[i]  <= d2_r[i][DIFF_W-1] ? POS_W'(-d2_r[i]) : POS_W'(d2_r[i]);
        d3_r[i]  <= d2_r[i];
        sq4_r[i] <= prod[i][2*POS_W-1:FRAC_BITS];
        d4_r[i]  <= d3_r[i];
        d5_r[i]  <= d4_r[i];
        d6_r[i]  <= d5_r[i];
      end
      r2_5_r <= R2_W'(sq4_r[0]) + R2_W'(sq4_r[1]) + R2_W'(sq4_r[2]);
      r2_6_r <= r2_5_r;
      rng6_r <= (r2_5_r != '0) && (CMP_W'(r2_5_r) < CMP_W'(cutoff));
    end
  end

  assign vld_o  = v_r[NSTG-1];
  assign r2_o   = r2_6_r;
  assign rng_o  = rng6_r;
  assign d_o.dx = d6_r[0];
  assign d_o.dy = d6_r[1];
  assign d_o.dz = d6_r[2];

endmodule

// ===== hw/rtl/ljpf_recip.sv =====
// Pipelined restoring divider for 2^(2F) / r2, one quotient bit per stage.
module ljpf_recip
  import ljpf_pkg::*;
#(
  parameter int FRAC_BITS = 16,
  localparam int R2_W = 2 * POS_W + 2 - FRAC_BITS,
  localparam int Q_W  = 2 * FRAC_BITS + 1
) (
  input  logic            clk,
  input  logic            en,
  input  logic [R2_W-1:0] den_i,
  output logic [Q_W-1:0]  quo_o
);

  logic [R2_W-1:0] rem_r   [Q_W-1];
  logic [R2_W-1:0] den_r   [Q_W-1];
  logic [Q_W-1:0]  quo_r   [Q_W];
  logic [R2_W-1:0] rem_nxt [Q_W-1];
  logic [Q_W-1:0]  quo_nxt [Q_W];

  // The dividend has a single set bit, which enters at the first stage.
  always_comb begin
    logic [R2_W-1:0] rin, din;
    logic [Q_W-1:0]  qin;
    logic [R2_W:0]   trial;
    logic            take;
    for (int s = 0; s < Q_W; s++) begin
      if (s == 0) begin
        rin = '0;
        din = den_i;
        qin = '0;
      end else begin
        rin = rem_r[s-1];
        din = den_r[s-1];
        qin = quo_r[s-1];
      end
      trial = {rin, (s == 0) ? 1'b1 : 1'b0};
      take  = trial >= {1'b0, din};
      if (s < Q_W - 1) begin
        rem_nxt[s] = take ? R2_W'(trial - {1'b0, din}) : trial[R2_W-1:0];
      end
      quo_nxt[s] = {qin[Q_W-2:0], take};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < Q_W; s++) begin
        quo_r[s] <= quo_nxt[s];
        if (s < Q_W - 1) begin
          rem_r[s] <= rem_nxt[s];
          den_r[s] <= (s == 0) ? den_i : den_r[s-1];
        end
      end
    end
  end

  assign quo_o = quo_r[Q_W-1];

endmodule

// ===== hw/rtl/lennard_jones_pair_force.sv =====
// Top level of the Lennard-Jones 12-6 pair force pipeline with minimum-image distance.
// The block takes one particle pair per beat on the in_ channel and returns one
// result beat per pair on the out_ channel, in order. It accepts a new pair every
// clock cycle while in_ready is high. Each pair passes through the geometry stages,
// the bit-per-stage divider that forms 1/r^2 and six ranks of three-stage multipliers
// in turn. The whole pipeline advances together; a two-entry output buffer lets it
// keep moving after the consumer stops until a result finds the output register full,
// so in_ready drops only when both output entries are full. Pairs at zero
// distance or at or beyond the cutoff return all-zero forces and energy with
// out_in_range clear. Configuration is written through cfg_we, cfg_index and
// cfg_wdata and must only change while no pair is in flight.
module lennard_jones_pair_force
  import ljpf_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  cfg_idx_t                cfg_index,
  input  logic [CFG_W-1:0]        cfg_wdata,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [POS_W-1:0]        in_first_x,
  input  logic [POS_W-1:0]        in_first_y,
  input  logic [POS_W-1:0]        in_first_z,
  input  logic [POS_W-1:0]        in_second_x,
  input  logic [POS_W-1:0]        in_second_y,
  input  logic [POS_W-1:0]        in_second_z,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [RES_W-1:0] out_force_x,
  output logic signed [RES_W-1:0] out_force_y,
  output logic signed [RES_W-1:0] out_force_z,
  output logic signed [RES_W-1:0] out_pair_energy,
  output logic                    out_in_range
);

  localparam int R2_W = 2 * POS_W + 2 - FRAC_BITS;
  localparam int Q_W  = 2 * FRAC_BITS + 1;

  // Side data that travels beside the arithmetic, one struct per section.
  typedef struct packed {
    logic   rng;
    diff3_t d;
  } side_a_t;

  typedef struct packed {
    logic             rng;
    diff3_t           d;
    logic [CAP_W-1:0] s2;
    logic [CAP_W-1:0] k;
  } side_b_t;

  typedef struct packed {
    logic             rng;
    diff3_t           d;
    logic [CAP_W-1:0] k;
  } side_c_t;

  typedef struct packed {
    logic             rng;
    diff3_t           d;
    logic [CAP_W-1:0] k;
    logic [CAP_W-1:0] s6;
  } side_d_t;

  typedef struct packed {
    logic   rng;
    diff3_t d;
    logic   e_neg;
    logic   g_neg;
  } side_e_t;

  typedef struct packed {
    logic                    rng;
    logic [2:0]              d_neg;
    logic                    g_neg;
    logic signed [RES_W-1:0] energy;
  } side_f_t;

  typedef struct packed {
    logic signed [RES_W-1:0] fx;
    logic signed [RES_W-1:0] fy;
    logic signed [RES_W-1:0] fz;
    logic signed [RES_W-1:0] energy;
    logic                    rng;
  } result_t;

  // Configuration registers.
  logic [POS_W-1:0]  box_length_r;
  logic [CUT_W-1:0]  cutoff_sq_r;
  logic [COEF_W-1:0] sigma_sq_r;
  logic [COEF_W-1:0] epsilon_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_length_r <= POS_W'(655360);
      cutoff_sq_r  <= CUT_W'(409600);
      sigma_sq_r   <= COEF_W'(65536);
      epsilon_r    <= COEF_W'(65536);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BOX_LENGTH: box_length_r <= cfg_wdata[POS_W-1:0];
        CFG_CUTOFF_SQ:  cutoff_sq_r  <= cfg_wdata[CUT_W-1:0];
        CFG_SIGMA_SQ:   sigma_sq_r   <= cfg_wdata[COEF_W-1:0];
        CFG_EPSILON:    epsilon_r    <= cfg_wdata[COEF_W-1:0];
        default: ;
      endcase
    end
  end

  // Every stage moves together while the output skid entry is free.
  logic en;
  logic skid_vld_r;

  assign en       = !skid_vld_r;
  assign in_ready = en;

  // Geometry: separation, r^2 and the range test.
  logic            g_vld, g_rng;
  logic [R2_W-1:0] g_r2;
  diff3_t          g_d;

  ljpf_geom #(.FRAC_BITS(FRAC_BITS)) u_geom (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .vld_i   (in_valid),
    .a_x     (in_first_x),
    .a_y     (in_first_y),
    .a_z     (in_first_z),
    .b_x     (in_second_x),
    .b_y     (in_second_y),
    .b_z     (in_second_z),
    .box_len (box_length_r),
    .cutoff  (cutoff_sq_r),
    .vld_o   (g_vld),
    .r2_o    (g_r2),
    .rng_o   (g_rng),
    .d_o     (g_d)
  );

  // Reciprocal of r^2. Out-of-range pairs may divide by zero; their result is dropped.
  logic [Q_W-1:0] inv;
  side_a_t        sa_in, sa0, sa1;
  logic           va0, va1;

  assign sa_in.rng = g_rng;
  assign sa_in.d   = g_d;

  ljpf_recip #(.FRAC_BITS(FRAC_BITS)) u_recip (
    .clk   (clk),
    .en    (en),
    .den_i (g_r2),
    .quo_o (inv)
  );

  ljpf_delay #(.W($bits(side_a_t)), .DEPTH(Q_W)) u_dly_recip (
    .clk (clk), .rst_n (rst_n), .en (en),
    .vld_i (g_vld), .d_i (sa_in), .vld_o (va0), .d_o (sa0)
  );

  // s2 = sigma^2 / r^2 and k = epsilon / r^2.
  logic [CAP_W-1:0] s2, k;

  ljpf_mulq #(.FRAC_BITS(FRAC_BITS)) u_mul_s2 (
    .clk (clk), .en (en),
    .a_i (OP_W'(sigma_sq_r)), .b_i (OP_W'(inv)), .p_o (s2)
  );

  ljpf_mulq #(.FRAC_BITS(FRAC_BITS)) u_mul_k (
    .clk (clk), .en (en),
    .a_i (OP_W'(epsilon_r)), .b_i (OP_W'(inv)), .p_o (k)
  );

  ljpf_delay #(.W($bits(side_a_t)), .DEPTH(MUL_LAT)) u_dly_m1 (
    .clk (clk), .rst_n (rst_n), .en (en),
    .vld_i (va0), .d_i (sa0), .vld_o (va1), .d_o (sa1)
  );

  // s4 = s2 * s2.
  logic [CAP_W-1:0] s4;
  side_b_t          sb_in, sb;
  logic             vb;

  assign sb_in.rng = sa1.rng;
  assign sb_in.d   = sa1.d;
  assign sb_in.s2  = s2;
  assign sb_in.k   = k;

  ljpf_mulq #(.FRAC_BITS(FRAC_BITS)) u_mul_s4 (
    .clk (clk), .en (en),
    .a_i (OP_W'(s2)), .b_i (OP_W'(s2)), .p_o (s4)
  );

  ljpf_delay #(.W($bits(side_b_t)), .DEPTH(MUL_LAT)) u_dly_m2 (
    .clk (clk), .rst_n (rst_n), .en (en),
    .vld_i (va1), .d_i (sb_in), .vld_o (vb), .d_o (sb)
  );

  // s6 = s4 * s2.
  logic [CAP_W-1:0] s6;
  side_c_t          sc_in, sc;
  logic             vc;

  assign sc_in.rng = sb.rng;
  assign sc_in.d   = sb.d;
  assign sc_in.k   = sb.k;

  ljpf_mulq #(.FRAC_BITS(FRAC_BITS)) u_mul_s6 (
    .clk (clk), .en (en),
    .a_i (OP_W'(s4)), .b_i (OP_W'(sb.s2)), .p_o (s6)
  );

  ljpf_delay #(.W($bits(side_c_t)), .DEPTH(MUL_LAT)) u_dly_m3 (
    .clk (clk), .rst_n (rst_n), .en (en),
    .vld_i (vb), .d_i (sc_in), .vld_o (vc), .d_o (sc)
  );

  // s12 = s6 * s6.
  logic [CAP_W-1:0] s12;
  side_d_t          sd_in, sd;
  logic             vd;

  assign sd_in.rng = sc.rng;
  assign sd_in.d   = sc.d;
  assign sd_in.k   = sc.k;
  assign sd_in.s6  = s6;

  ljpf_mulq #(.FRAC_BITS(FRAC_BITS)) u_mul_s12 (
    .clk (clk), .en (en),
    .a_i (OP_W'(s6)), .b_i (OP_W'(s6)), .p_o (s12)
  );

  ljpf_delay #(.W($bits(side_d_t)), .DEPTH(MUL_LAT)) u_dly_m4 (
    .clk (clk), .rst_n (rst_n), .en (en),
    .vld_i (vc), .d_i (sd_in), .vld_o (vd), .d_o (sd)
  );

  // Energy bracket s12 - s6 and force bracket 2*s12 - s6, kept as sign and magnitude.
  logic signed [MAG_W-1:0] ediff, gval;
  logic                    e_vld_r, e_rng_r, e_eneg_r, e_gneg_r;
  diff3_t                  e_d_r;
  logic [CAP_W-1:0]        e_k_r, e_emag_r;
  logic [CAP_W:0]          e_gmag_r;

  assign ediff = $signed({2'b00, s12}) - $signed({2'b00, sd.s6});
  assign gval  = $signed({1'b0, s12, 1'b0}) - $signed({2'b00, sd.s6});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_vld_r <= 1'b0;
    end else if (en) begin
      e_vld_r <= vd;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_rng_r  <= sd.rng;
      e_d_r    <= sd.d;
      e_k_r    <= sd.k;
      e_eneg_r <= ediff[MAG_W-1];
      e_emag_r <= ediff[MAG_W-1] ? CAP_W'(-ediff) : CAP_W'(ediff);
      e_gneg_r <= gval[MAG_W-1];
      e_gmag_r <= gval[MAG_W-1] ? (CAP_W+1)'(-gval) : (CAP_W+1)'(gval);
    end
  end

  // Energy magnitude epsilon * bracket, and q = k * force bracket.
  logic [CAP_W-1:0] em, qm;
  side_e_t          se_in, se;
  logic             ve;

  assign se_in.rng   = e_rng_r;
  assign se_in.d     = e_d_r;
  assign se_in.e_neg = e_eneg_r;
  assign se_in.g_neg = e_gneg_r;

  ljpf_mulq #(.FRAC_BITS(FRAC_BITS)) u_mul_em (
    .clk (clk), .en (en),
    .a_i (OP_W'(epsilon_r)), .b_i (OP_W'(e_emag_r)), .p_o (em)
  );

  ljpf_mulq #(.FRAC_BITS(FRAC_BITS)) u_mul_q (
    .clk (clk), .en (en),
    .a_i (OP_W'(e_k_r)), .b_i (OP_W'(e_gmag_r)), .p_o (qm)
  );

  ljpf_delay #(.W($bits(side_e_t)), .DEPTH(MUL_LAT)) u_dly_m5 (
    .clk (clk), .rst_n (rst_n), .en (en),
    .vld_i (e_vld_r), .d_i (se_in), .vld_o (ve), .d_o (se)
  );

  // Radial force 24*q clamped to the cap, final energy 4*em saturated, and |d| per axis.
  logic                    r_vld_r, r_rng_r, r_gneg_r;
  logic [CAP_W-1:0]        r_frm_r;
  logic [POS_W-1:0]        r_dmag_r [3];
  logic [2:0]              r_dneg_r;
  logic signed [RES_W-1:0] r_energy_r;
  diff_t                   se_d [3];
  logic [CAP_W+4:0]        q24;

  assign se_d[0] = se.d.dx;
  assign se_d[1] = se.d.dy;
  assign se_d[2] = se.d.dz;
  assign q24     = {1'b0, qm, 4'b0000} + {2'b00, qm, 3'b000};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r_vld_r <= 1'b0;
    end else if (en) begin
      r_vld_r <= ve;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_rng_r    <= se.rng;
      r_gneg_r   <= se.g_neg;
      r_frm_r    <= (qm > FR_LIMIT) ? CAP : q24[CAP_W-1:0];
      r_energy_r <= sat_mag(se.e_neg, {em, 2'b00});
      for (int i = 0; i < 3; i++) begin
        r_dneg_r[i] <= se_d[i][DIFF_W-1];
        r_dmag_r[i] <= se_d[i][DIFF_W-1] ? POS_W'(-se_d[i]) : POS_W'(se_d[i]);
      end
    end
  end

  // Force components |fr| * |d| per axis.
  logic [CAP_W-1:0] fm [3];
  side_f_t          sf_in, sf;
  logic             vf;

  assign sf_in.rng    = r_rng_r;
  assign sf_in.d_neg  = r_dneg_r;
  assign sf_in.g_neg  = r_gneg_r;
  assign sf_in.energy = r_energy_r;

  for (genvar i = 0; i < 3; i++) begin : g_force
    ljpf_mulq #(.FRAC_BITS(FRAC_BITS)) u_mul_f (
      .clk (clk), .en (en),
      .a_i (OP_W'(r_frm_r)), .b_i (OP_W'(r_dmag_r[i])), .p_o (fm[i])
    );
  end

  ljpf_delay #(.W($bits(side_f_t)), .DEPTH(MUL_LAT)) u_dly_m6 (
    .clk (clk), .rst_n (rst_n), .en (en),
    .vld_i (r_vld_r), .d_i (sf_in), .vld_o (vf), .d_o (sf)
  );

  // Apply signs, saturate, and zero everything for pairs outside the cutoff or at zero distance.
  result_t res;

  always_comb begin
    res.rng    = sf.rng;
    res.fx     = sf.rng ? sat_mag(sf.g_neg ^ sf.d_neg[0], MAG_W'(fm[0])) : '0;
    res.fy     = sf.rng ? sat_mag(sf.g_neg ^ sf.d_neg[1], MAG_W'(fm[1])) : '0;
    res.fz     = sf.rng ? sat_mag(sf.g_neg ^ sf.d_neg[2], MAG_W'(fm[2])) : '0;
    res.energy = sf.rng ? sf.energy : '0;
  end

  // Output register plus one skid entry. A result that cannot go straight to the
  // output register parks in the skid entry, and that stalls the pipeline.
  logic    out_vld_r;
  result_t out_r, skid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (skid_vld_r) begin
      if (out_ready) begin
        skid_vld_r <= 1'b0;
      end
    end else if (vf) begin
      if (!out_vld_r || out_ready) begin
        out_vld_r <= 1'b1;
      end else begin
        skid_vld_r <= 1'b1;
      end
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_vld_r) begin
      if (out_ready) begin
        out_r <= skid_r;
      end
    end else if (vf) begin
      if (!out_vld_r || out_ready) begin
        out_r <= res;
      end else begin
        skid_r <= res;
      end
    end
  end

  assign out_valid       = out_vld_r;
  assign out_force_x     = out_r.fx;
  assign out_force_y     = out_r.fy;
  assign out_force_z     = out_r.fz;
  assign out_pair_energy = out_r.energy;
  assign out_in_range    = out_r.rng;

endmodule
